### src/nigbp_pkg.sv
// Package for the NAND-indexed global-history branch predictor.
// Holds the mode and state types and the default sizes; no dependencies.
`timescale 1ns / 1ps

package nigbp_pkg;

  // Default table geometry
  localparam int INDEX_BITS_DEF   = 12;
  localparam int COUNTER_BITS_DEF = 2;

  // Fixed field widths
  localparam int ADDR_W    = 12;
  localparam int HIST_W    = 16;
  localparam int HLEN_W    = 5;
  localparam int RCTR_W    = 8;
  localparam int HLEN_MAX  = 16;
  localparam logic [HLEN_W-1:0] HLEN_RESET = 5'd12;

  // Item modes
  typedef enum logic [1:0] {
    MODE_LOOKUP = 2'd0,
    MODE_UNCOND = 2'd1,
    MODE_UPDATE = 2'd2,
    MODE_SQUASH = 2'd3
  } mode_t;

  // Control states
  typedef enum logic {
    ST_CLEAR = 1'b0,
    ST_RUN   = 1'b1
  } state_t;

endpackage

### src/nigbp_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// Read-first on a same-address write; no dependencies.
`timescale 1ns / 1ps

module nigbp_ram #(
  parameter int WIDTH = 2,
  parameter int DEPTH = 4096
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write and registered read; rdata holds when re is low
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

### src/nand_indexed_global_branch_predictor_unit.sv
// Branch predictor: one item per cycle unless in_stall is high; the table is
// read at accept, the result registered when the execute stage advances.
// Throughput is set by the single read-modify-write of the counter RAM; a write
// to the entry just read is forwarded from a one-entry bypass register.
// After reset a clearing pass zeroes all 2^INDEX_BITS entries (4096 by default),
// with in_stall high; configuration writes are taken during it.
`timescale 1ns / 1ps

module nand_indexed_global_branch_predictor_unit #(
  parameter int INDEX_BITS   = nigbp_pkg::INDEX_BITS_DEF,
  parameter int COUNTER_BITS = nigbp_pkg::COUNTER_BITS_DEF
) (
  input  logic                        clk,
  input  logic                        rst,
  // configuration
  input  logic                        cfg_we,
  input  logic [nigbp_pkg::HLEN_W-1:0] cfg_wdata,
  // input channel
  input  logic                        in_valid,
  output logic                        in_stall,
  input  nigbp_pkg::mode_t            mode,
  input  logic [nigbp_pkg::ADDR_W-1:0] branch_address,
  input  logic                        outcome_taken,
  input  logic [nigbp_pkg::ADDR_W-1:0] saved_index,
  input  logic [nigbp_pkg::HIST_W-1:0] saved_history,
  input  logic                        saved_from_uncond,
  // output channel
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic                        predict_taken,
  output logic [nigbp_pkg::ADDR_W-1:0] record_index,
  output logic [nigbp_pkg::HIST_W-1:0] record_history,
  output logic [nigbp_pkg::RCTR_W-1:0] record_counter,
  output logic                        record_uncond
);

  import nigbp_pkg::*;

  localparam logic [COUNTER_BITS-1:0] CTR_MAX = {COUNTER_BITS{1'b1}};

  state_t                  state, state_next;
  logic [INDEX_BITS-1:0]   clr_addr;
  logic [HLEN_W-1:0]       hist_len;
  logic [HIST_W-1:0]       global_history, global_history_next;

  logic                    in_acc;
  logic [HLEN_W-1:0]       len_cap;
  logic [HIST_W:0]         mask_w;
  logic [HIST_W-1:0]       hmask, and_w, sidx_w;
  logic [INDEX_BITS-1:0]   rd_idx;

  // execute stage
  logic                    s1_valid, s1_adv;
  mode_t                   s1_mode;
  logic                    s1_taken, s1_suncond;
  logic [INDEX_BITS-1:0]   s1_idx;
  logic [HIST_W-1:0]       s1_hist;

  // bypass of the last table write
  logic                    fwd_valid;
  logic [INDEX_BITS-1:0]   fwd_addr;
  logic [COUNTER_BITS-1:0] fwd_data;

  logic [COUNTER_BITS-1:0] ram_rdata, ctr, ctr_new;
  logic                    ram_we, upd_we;
  logic [INDEX_BITS-1:0]   ram_waddr;
  logic [COUNTER_BITS-1:0] ram_wdata;

  // State register and clearing counter
  always_ff @(posedge clk) begin
    if (rst) begin
      state    <= ST_CLEAR;
      clr_addr <= '0;
    end else begin
      state <= state_next;
      if (state == ST_CLEAR) begin
        clr_addr <= clr_addr + 1'b1;
      end
    end
  end

  // Leave the clearing pass after the last entry
  always_comb begin
    state_next = state;
    case (state)
      ST_CLEAR: begin
        if (&clr_addr) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN:  state_next = ST_RUN;
      default: state_next = ST_CLEAR;
    endcase
  end

  // Configuration register
  always_ff @(posedge clk) begin
    if (rst) begin
      hist_len <= HLEN_RESET;
    end else if (cfg_we) begin
      hist_len <= cfg_wdata;
    end
  end

  // Handshake
  assign s1_adv   = !out_valid || !out_stall;
  assign in_stall = (state != ST_RUN) || (s1_valid && !s1_adv);
  assign in_acc   = in_valid && !in_stall;

  // History mask and table index
  assign len_cap = (hist_len > HLEN_W'(HLEN_MAX)) ? HLEN_W'(HLEN_MAX) : hist_len;
  assign mask_w  = ((HIST_W + 1)'(1) << len_cap) - (HIST_W + 1)'(1);
  assign hmask   = mask_w[HIST_W-1:0];
  assign and_w   = HIST_W'(branch_address) & global_history & hmask;
  assign sidx_w  = HIST_W'(saved_index);

  always_comb begin
    case (mode)
      MODE_LOOKUP: rd_idx = ~and_w[INDEX_BITS-1:0];
      MODE_UPDATE: rd_idx = sidx_w[INDEX_BITS-1:0];
      default:     rd_idx = '0;
    endcase
  end

  // History moves at accept; it never depends on the counter
  always_comb begin
    case (mode)
      MODE_UNCOND: global_history_next = {global_history[HIST_W-2:0], 1'b1} & hmask;
      MODE_UPDATE: global_history_next = {global_history[HIST_W-2:0], outcome_taken} & hmask;
      MODE_SQUASH: global_history_next = saved_history;
      default:     global_history_next = global_history;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      global_history <= '0;
    end else if (in_acc) begin
      global_history <= global_history_next;
    end
  end

  // Capture the item into the execute stage
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (in_acc) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_mode    <= mode;
      s1_taken   <= outcome_taken;
      s1_suncond <= saved_from_uncond;
      s1_idx     <= rd_idx;
      s1_hist    <= global_history;
    end
  end

  // Counter read, with bypass of the write made at the read edge
  assign ctr = (fwd_valid && fwd_addr == s1_idx) ? fwd_data : ram_rdata;

  // Saturating train step
  always_comb begin
    ctr_new = ctr;
    if (s1_taken && ctr != CTR_MAX) begin
      ctr_new = ctr + 1'b1;
    end else if (!s1_taken && ctr != '0) begin
      ctr_new = ctr - 1'b1;
    end
  end

  assign upd_we    = s1_valid && s1_adv && (s1_mode == MODE_UPDATE) && !s1_suncond;
  assign ram_we    = (state == ST_CLEAR) || upd_we;
  assign ram_waddr = (state == ST_CLEAR) ? clr_addr : s1_idx;
  assign ram_wdata = (state == ST_CLEAR) ? '0 : ctr_new;

  // Track the latest write for the bypass
  always_ff @(posedge clk) begin
    if (rst || state == ST_CLEAR) begin
      fwd_valid <= 1'b0;
    end else if (upd_we) begin
      fwd_valid <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (upd_we) begin
      fwd_addr <= s1_idx;
      fwd_data <= ctr_new;
    end
  end

  nigbp_ram #(
    .WIDTH (COUNTER_BITS),
    .DEPTH (2 ** INDEX_BITS)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (in_acc),
    .raddr (rd_idx),
    .rdata (ram_rdata)
  );

  // Output register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_valid && s1_adv) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid && s1_adv) begin
      case (s1_mode)
        MODE_LOOKUP: begin
          predict_taken  <= ctr[COUNTER_BITS-1];
          record_index   <= ADDR_W'(s1_idx);
          record_history <= s1_hist;
          record_counter <= RCTR_W'(ctr);
          record_uncond  <= 1'b0;
        end
        MODE_UNCOND: begin
          predict_taken  <= 1'b1;
          record_index   <= '0;
          record_history <= s1_hist;
          record_counter <= RCTR_W'(CTR_MAX);
          record_uncond  <= 1'b1;
        end
        default: begin
          predict_taken  <= 1'b0;
          record_index   <= '0;
          record_history <= '0;
          record_counter <= '0;
          record_uncond  <= 1'b0;
        end
      endcase
    end
  end

endmodule
